// ----- rtl/core/bli_pkg.sv -----
`timescale 1ns / 1ps

package bli_pkg;

  // Default depth of the instruction store and the bracket stack.
  localparam int unsigned PROGRAM_DEPTH_DEF = 4096;

  // Longest run that one add, sub, left or right token can carry.
  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  // Width of one stored token: opcode on top, argument below.
  localparam int unsigned TOK_W = 20;

  // Opcodes of the stored tokens.
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_LEFT  = 4'd2;
  localparam logic [3:0] OP_RIGHT = 4'd3;
  localparam logic [3:0] OP_PUTCH = 4'd4;
  localparam logic [3:0] OP_READ  = 4'd5;
  localparam logic [3:0] OP_JZ    = 4'd6;
  localparam logic [3:0] OP_JNZ   = 4'd7;
  localparam logic [3:0] OP_CLEAR = 4'd8;

  // Status codes; the first error that occurs is kept.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_OPEN  = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  // Source characters that mean something.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Action codes of an input item.
  localparam logic ACT_FEED = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // One input item.
  typedef struct packed {
    logic        action;
    logic [7:0]  source_byte;
    logic        final_byte;
    logic [11:0] read_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] instr_count;
    logic        complete;
    logic [3:0]  opcode;
    logic [15:0] argument;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic run;
    logic tok;
    logic jzfix;
    logic finish;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_run;
    logic is_final;
    logic jz_fix;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/bli_ctrl.sv -----
`timescale 1ns / 1ps

module bli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  output bli_pkg::cmd_t cmd,
  input  bli_pkg::sts_t sts
);
  import bli_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_TOK   = 6'b000100,
    S_JZFIX = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // A read has its store data registered at the transfer edge.
          state_nxt  = (in_action == ACT_READ) ? S_OUT : S_RUN;
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (!sts.is_run) begin
          state_nxt = S_TOK;
        end else begin
          state_nxt = sts.is_final ? S_FIN : S_OUT;
        end
      end
      S_TOK: begin
        cmd.tok = 1'b1;
        if (sts.jz_fix) begin
          state_nxt = S_JZFIX;
        end else begin
          state_nxt = sts.is_final ? S_FIN : S_OUT;
        end
      end
      S_JZFIX: begin
        cmd.jzfix = 1'b1;
        state_nxt = sts.is_final ? S_FIN : S_OUT;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/bli_dp.sv -----
`timescale 1ns / 1ps

module bli_dp #(
  parameter int unsigned PROGRAM_DEPTH = bli_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bli_pkg::in_item_t  in_data,
  input  bli_pkg::cmd_t      cmd,
  output bli_pkg::sts_t      sts,
  input  logic               out_ready,
  output logic               out_valid,
  output bli_pkg::out_item_t out_data
);
  import bli_pkg::*;

  localparam int unsigned AW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = (CW > 12) ? CW : 12;
  localparam logic [CW-1:0] DEPTH_C = CW'(PROGRAM_DEPTH);

  // Instruction store and bracket stack, both single port.
  logic [TOK_W-1:0] instr_mem [PROGRAM_DEPTH];
  logic [AW-1:0]    stk_mem [PROGRAM_DEPTH];
  logic [TOK_W-1:0] rd_tok_r;
  logic [AW-1:0]    stk_rd_r;

  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  logic [TOK_W-1:0] mem_wd;
  logic             stk_we;
  logic             stk_re;
  logic [AW-1:0]    stk_addr;

  // Control state.
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] level_r, level_nxt;
  logic [7:0]    run_char_r, run_char_nxt;
  logic [15:0]   run_len_r, run_len_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          fin_r, fin_nxt;
  logic          top_jz_r, top_jz_nxt;
  logic          pat_r, pat_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers.
  in_item_t      item_r;
  logic          hit_r;
  out_item_t     out_data_r;

  logic [7:0]    src;
  logic          is_run;
  logic          run_pending;
  logic          run_extend;
  logic [3:0]    run_op;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_m2;
  logic [CW-1:0] lvl_dec;
  logic [XW-1:0] idx_x;
  logic          rd_hit;
  logic          restart;

  logic          emit_req;
  logic [3:0]    emit_op;
  logic [15:0]   emit_arg;
  logic          emit_ok;
  logic          emit_ovf;

  assign src         = item_r.source_byte;
  assign is_run      = (src == CH_PLUS) || (src == CH_MINUS) ||
                       (src == CH_LT) || (src == CH_GT);
  assign run_pending = (run_len_r != 16'd0);
  assign run_extend  = is_run && run_pending && (run_char_r == src) &&
                       (run_len_r < RUN_MAX);
  assign count_m1    = count_r - CW'(1);
  assign count_m2    = count_r - CW'(2);
  assign lvl_dec     = level_r - CW'(1);
  assign idx_x       = XW'(in_data.read_index);
  assign rd_hit      = (idx_x < XW'(count_r));
  assign restart     = cmd.accept && (in_data.action == ACT_FEED) && fin_r;

  // Token kind of the pending run.
  always_comb begin
    priority if (run_char_r == CH_PLUS) begin
      run_op = OP_ADD;
    end else if (run_char_r == CH_MINUS) begin
      run_op = OP_SUB;
    end else if (run_char_r == CH_LT) begin
      run_op = OP_LEFT;
    end else begin
      run_op = OP_RIGHT;
    end
  end

  // Token to append in this cycle, if any.
  always_comb begin
    emit_req = 1'b0;
    emit_op  = run_op;
    emit_arg = run_len_r;
    if (cmd.run) begin
      emit_req = run_pending && !run_extend;
    end else if (cmd.finish) begin
      // The last byte always flushes whatever run is still pending.
      emit_req = run_pending;
    end else if (cmd.tok) begin
      priority if (src == CH_DOT) begin
        emit_req = 1'b1;
        emit_op  = OP_PUTCH;
        emit_arg = 16'd0;
      end else if (src == CH_COMMA) begin
        emit_req = 1'b1;
        emit_op  = OP_READ;
        emit_arg = 16'd0;
      end else if (src == CH_LBR) begin
        emit_req = 1'b1;
        emit_op  = OP_JZ;
        emit_arg = 16'd0;
      end else if (src == CH_RBR) begin
        emit_req = (err_r == ST_OK) && !pat_r && (level_r != '0);
        emit_op  = OP_JNZ;
        emit_arg = 16'(stk_rd_r);
      end else begin
        emit_req = 1'b0;
      end
    end
  end

  assign emit_ok  = emit_req && (err_r == ST_OK) && (count_r < DEPTH_C);
  assign emit_ovf = emit_req && (err_r == ST_OK) && (count_r >= DEPTH_C);

  // Next state of the builder and memory port control.
  always_comb begin
    count_nxt    = count_r;
    level_nxt    = level_r;
    run_char_nxt = run_char_r;
    run_len_nxt  = run_len_r;
    err_nxt      = err_r;
    fin_nxt      = fin_r;
    top_jz_nxt   = top_jz_r;
    pat_nxt      = pat_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = count_r[AW-1:0];
    mem_wd       = {emit_op, emit_arg};
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_addr     = level_r[AW-1:0];

    // Append a token; track whether the top two form a jz then a unit add or sub.
    if (emit_ok) begin
      mem_we     = 1'b1;
      count_nxt  = count_r + CW'(1);
      top_jz_nxt = (emit_op == OP_JZ);
      pat_nxt    = top_jz_r && ((emit_op == OP_ADD) || (emit_op == OP_SUB)) &&
                   (emit_arg == 16'd1);
    end
    if (emit_ovf) begin
      err_nxt = ST_OVF;
    end

    // Transfer in: a feed after completion starts a new program.
    if (cmd.accept) begin
      if (restart) begin
        count_nxt    = '0;
        level_nxt    = '0;
        run_char_nxt = 8'd0;
        run_len_nxt  = 16'd0;
        err_nxt      = ST_OK;
        fin_nxt      = 1'b0;
        top_jz_nxt   = 1'b0;
        pat_nxt      = 1'b0;
      end
      if (in_data.action == ACT_READ) begin
        mem_re   = 1'b1;
        mem_addr = idx_x[AW-1:0];
      end
    end

    // Run phase: extend or restart the run, or flush it before another byte.
    if (cmd.run) begin
      if (is_run) begin
        if (run_extend) begin
          run_len_nxt = run_len_r + 16'd1;
        end else begin
          run_char_nxt = src;
          run_len_nxt  = 16'd1;
        end
      end else begin
        run_len_nxt = 16'd0;
        if (src == CH_RBR) begin
          stk_re   = 1'b1;
          stk_addr = lvl_dec[AW-1:0];
        end
      end
    end

    // Token phase: brackets work on the stack.
    if (cmd.tok) begin
      if (src == CH_LBR) begin
        if (emit_ok && (level_r < DEPTH_C)) begin
          stk_we    = 1'b1;
          stk_addr  = level_r[AW-1:0];
          level_nxt = level_r + CW'(1);
        end
      end else if (src == CH_RBR) begin
        if (err_r == ST_OK) begin
          if (pat_r) begin
            // Loop over a single unit step collapses into a clear token.
            mem_we     = 1'b1;
            mem_addr   = count_m2[AW-1:0];
            mem_wd     = {OP_CLEAR, 16'd0};
            count_nxt  = count_m1;
            top_jz_nxt = 1'b0;
            pat_nxt    = 1'b0;
            if (level_r != '0) begin
              level_nxt = lvl_dec;
            end
          end else if (level_r == '0) begin
            err_nxt = ST_CLOSE;
          end else if (emit_ok) begin
            level_nxt = lvl_dec;
          end
        end
      end
    end

    // Back-patch the open bracket with the index of its partner.
    if (cmd.jzfix) begin
      mem_we   = 1'b1;
      mem_addr = stk_rd_r;
      mem_wd   = {OP_JZ, 16'(count_m1)};
    end

    // Last byte: flush the run, then report brackets left open.
    if (cmd.finish) begin
      run_len_nxt = 16'd0;
      fin_nxt     = 1'b1;
      if (!emit_ovf && (err_r == ST_OK) && (level_r != '0)) begin
        err_nxt = ST_OPEN;
      end
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      level_r     <= '0;
      run_char_r  <= 8'd0;
      run_len_r   <= 16'd0;
      err_r       <= ST_OK;
      fin_r       <= 1'b0;
      top_jz_r    <= 1'b0;
      pat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      level_r     <= level_nxt;
      run_char_r  <= run_char_nxt;
      run_len_r   <= run_len_nxt;
      err_r       <= err_nxt;
      fin_r       <= fin_nxt;
      top_jz_r    <= top_jz_nxt;
      pat_r       <= pat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
      hit_r  <= rd_hit;
    end
    if (cmd.load_out) begin
      out_data_r.status      <= err_r;
      out_data_r.instr_count <= 13'(count_r);
      out_data_r.complete    <= fin_r;
      if ((item_r.action == ACT_READ) && hit_r) begin
        out_data_r.opcode   <= rd_tok_r[TOK_W-1:16];
        out_data_r.argument <= rd_tok_r[15:0];
      end else begin
        out_data_r.opcode   <= OP_ADD;
        out_data_r.argument <= 16'd0;
      end
    end
  end

  // Instruction store port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      instr_mem[mem_addr] <= mem_wd;
    end else if (mem_re) begin
      rd_tok_r <= instr_mem[mem_addr];
    end
  end

  // Bracket stack port.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= count_r[AW-1:0];
    end else if (stk_re) begin
      stk_rd_r <= stk_mem[stk_addr];
    end
  end

  assign sts.is_run   = is_run;
  assign sts.is_final = item_r.final_byte;
  assign sts.jz_fix   = cmd.tok && (src == CH_RBR) && emit_ok;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every open bracket on the stack has a stored jz token.
  a_level_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= count_r)
    else $error("bracket stack deeper than instruction count");

  // The store never holds more than its depth.
  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("instruction count beyond store depth");

  // A clear candidate ends in an add or sub, so its top is not a jz.
  a_pattern_shape: assert property (@(posedge clk) disable iff (!rst_n)
    pat_r |-> (!top_jz_r && (count_r >= CW'(2))))
    else $error("clear candidate flags inconsistent");

  // Errors stay until a new program starts.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((err_r != ST_OK) && !restart) |=> $stable(err_r))
    else $error("error code changed without a restart");

endmodule

// ----- rtl/core/bracket_loop_ir_builder.sv -----
`timescale 1ns / 1ps
// A read goes from transfer in to the result step; a feed passes a run phase, a
// token phase for other bytes, a back-patch step after a stored closing bracket
// and a final-byte flush step, as the single-port store writes in separate steps.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: rst_n low (synchronous) empties the program, errors and run state.
// Store and stack contents are not cleared; only entries written are read.

module bracket_loop_ir_builder #(
  parameter int unsigned PROGRAM_DEPTH = bli_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bli_pkg::out_item_t out_data
);
  import bli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer for the phases of one item.
  bli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Token builder, store, stack and result register.
  bli_dp #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
